// File: rtl/sds_pkg.sv
// Package for the sorted deposit store: item types, status and mode codes,
// controller states and fixed field widths. No dependencies.
`default_nettype none
package sds_pkg;

  // Fixed field widths
  localparam int AMT_W   = 31;
  localparam int CNT_W   = 7;
  localparam int TOT_W   = 37;
  localparam int RANK_W  = 6;

  // Default depth of the cell row
  localparam int CAPACITY_DEF = 64;

  // Divider sizing: one quotient bit per step
  localparam int DIV_STEPS  = TOT_W;
  localparam int DIV_STEP_W = 6;

  // Mode codes of the input item
  localparam logic [1:0] MODE_DEPOSIT = 2'd0;
  localparam logic [1:0] MODE_QUERY   = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // Status codes of the result item
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NOT_POS  = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_NO_RANK  = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] amount;
    logic [RANK_W-1:0]  rank;
  } sds_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [CNT_W-1:0] entry_count;
    logic [TOT_W-1:0] total;
    logic [AMT_W-1:0] lowest;
    logic [AMT_W-1:0] mean;
    logic [AMT_W-1:0] entry_value;
  } sds_out_t;

  // Read buses that travel down the cell row, one cell per cycle
  typedef struct packed {
    logic [AMT_W-1:0] rank_val;
    logic [AMT_W-1:0] low_val;
  } sds_rd_t;

  // Insert broadcast shared by all cells
  typedef struct packed {
    logic             ins_en;
    logic [AMT_W-1:0] new_val;
    logic [CNT_W-1:0] count;
    logic [RANK_W-1:0] rank_addr;
    logic [RANK_W-1:0] low_addr;
  } sds_bcast_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } sds_state_t;

endpackage
`default_nettype wire

// File: rtl/sds_cell.sv
// One cell of the sorted row: holds one amount, shifts on insert and
// forwards the registered read buses. Depends on sds_pkg.
`default_nettype none
module sds_cell
  import sds_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic       clk,
  input  wire sds_bcast_t bcast,
  input  wire logic       prev_ge,
  input  wire logic [AMT_W-1:0] prev_val,
  input  wire sds_rd_t    prev_rd,
  output logic            ge,
  output logic [AMT_W-1:0] val,
  output sds_rd_t         rd
);

  logic [AMT_W-1:0] val_r, val_nxt;
  sds_rd_t          rd_r, rd_nxt;
  logic             occupied;

  // Occupied cells holding an amount not below the new one keep it
  assign occupied = (CNT_W'(IDX) < bcast.count);
  assign ge       = occupied && (val_r >= bcast.new_val);

  always_comb begin
    val_nxt = val_r;
    if (bcast.ins_en && !ge) begin
      val_nxt = prev_ge ? bcast.new_val : prev_val;
    end
  end

  // Capture own amount onto a bus when addressed, else pass the neighbor's
  always_comb begin
    rd_nxt.rank_val = (bcast.rank_addr == RANK_W'(IDX)) ? val_r : prev_rd.rank_val;
    rd_nxt.low_val  = (bcast.low_addr  == RANK_W'(IDX)) ? val_r : prev_rd.low_val;
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    rd_r  <= rd_nxt;
  end

  assign val = val_r;
  assign rd  = rd_r;

endmodule
`default_nettype wire

// File: rtl/sds_div.sv
// Restoring divider: total by count, one quotient bit per cycle.
// Depends on sds_pkg.
`default_nettype none
module sds_div
  import sds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [TOT_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  busy,
  output logic [TOT_W-1:0]      quotient
);

  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic [TOT_W-1:0]      q_r, q_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      dvs_r, dvs_nxt;
  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        diff;

  assign trial = {rem_r, q_r[TOT_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  // Load on start, then shift in one quotient bit per step
  always_comb begin
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      step_nxt = DIV_STEP_W'(DIV_STEPS);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (step_r != '0) begin
      step_nxt = step_r - 1'b1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[CNT_W-1:0];
        q_nxt   = {q_r[TOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        q_nxt   = {q_r[TOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (step_r != '0);
  assign quotient = q_r;

endmodule
`default_nettype wire

// File: rtl/sorted_deposit_store.sv
// Top level of the sorted deposit store: controller, cell row and divider.
// Depends on sds_pkg, sds_cell and sds_div.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+-------------------------------
//   input    | start, busy, in_data     | taken when start and !busy
//   result   | out_valid, out_data      | one-cycle strobe, no stall
//
// A deposit is placed into the cell row at the edge that takes the item.
// The read buses then cross the row one cell per cycle while the divider
// forms the mean one bit per cycle; the strobe follows once both are done,
// and busy is high from acceptance to the strobe.
// Synchronous active-low reset clears count, total and control; the cells
// hold no reset value and only occupied cells are ever reported.
`default_nettype none
module sorted_deposit_store
  import sds_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire sds_in_t in_data,
  output logic         out_valid,
  output sds_out_t     out_data
);

  localparam int SWP_W = $clog2(CAPACITY + 1);

  sds_state_t        state_r, state_nxt;
  logic [SWP_W-1:0]  swp_r, swp_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [RANK_W-1:0] low_r, low_nxt;
  logic              out_valid_r, out_valid_nxt;
  sds_out_t          out_data_r, out_data_nxt;

  logic              accept;
  logic              positive;
  logic              do_insert;
  logic              div_start;
  logic              div_busy;
  logic [TOT_W-1:0]  quot;
  sds_bcast_t        bcast;

  logic              ge   [CAPACITY];
  logic [AMT_W-1:0]  val  [CAPACITY];
  sds_rd_t           rd   [CAPACITY];

  assign accept    = start && (state_r == ST_IDLE);
  assign positive  = (in_data.amount > 32'sd0);
  assign do_insert = accept && (in_data.mode == MODE_DEPOSIT) && positive &&
                     (count_r < CNT_W'(CAPACITY));

  // Broadcast the insert and the two read addresses to every cell
  assign bcast.ins_en    = do_insert;
  assign bcast.new_val   = in_data.amount[AMT_W-1:0];
  assign bcast.count     = count_r;
  assign bcast.rank_addr = rank_r;
  assign bcast.low_addr  = low_r;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        sds_cell #(.IDX(gi)) u_cell (
          .clk      (clk),
          .bcast    (bcast),
          .prev_ge  (1'b1),
          .prev_val (bcast.new_val),
          .prev_rd  ('0),
          .ge       (ge[gi]),
          .val      (val[gi]),
          .rd       (rd[gi])
        );
      end else begin : g_body
        sds_cell #(.IDX(gi)) u_cell (
          .clk      (clk),
          .bcast    (bcast),
          .prev_ge  (ge[gi-1]),
          .prev_val (val[gi-1]),
          .prev_rd  (rd[gi-1]),
          .ge       (ge[gi]),
          .val      (val[gi]),
          .rd       (rd[gi])
        );
      end
    end
  endgenerate

  sds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  // Next state, item bookkeeping and result assembly
  always_comb begin
    state_nxt     = state_r;
    swp_nxt       = swp_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    status_nxt    = status_r;
    mode_nxt      = mode_r;
    rank_nxt      = rank_r;
    low_nxt       = low_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt   = in_data.mode;
          rank_nxt   = in_data.rank;
          swp_nxt    = '0;
          status_nxt = STAT_OK;
          if (in_data.mode == MODE_DEPOSIT) begin
            if (!positive) begin
              status_nxt = STAT_NOT_POS;
            end else if (!do_insert) begin
              status_nxt = STAT_FULL;
            end else begin
              count_nxt = count_r + 1'b1;
              total_nxt = total_r + TOT_W'(in_data.amount[AMT_W-1:0]);
            end
          end else if (in_data.mode == MODE_READ) begin
            if (CNT_W'(in_data.rank) >= count_r) begin
              status_nxt = STAT_NO_RANK;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
            end
          end
          low_nxt   = RANK_W'(count_nxt - 1'b1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        div_start = (swp_r == '0);
        if (swp_r != SWP_W'(CAPACITY)) begin
          swp_nxt = swp_r + 1'b1;
        end else if (!div_busy) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_count = count_r;
          out_data_nxt.total       = total_r;
          out_data_nxt.lowest      = (count_r == '0) ? '0 : rd[CAPACITY-1].low_val;
          out_data_nxt.mean        = (count_r == '0) ? '0 : quot[AMT_W-1:0];
          out_data_nxt.entry_value = ((mode_r == MODE_READ) && (status_r == STAT_OK)) ?
                                     rd[CAPACITY-1].rank_val : '0;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      swp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      swp_r       <= swp_nxt;
    end
    status_r   <= status_nxt;
    mode_r     <= mode_nxt;
    rank_r     <= rank_nxt;
    low_r      <= low_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
